### hw/rtl/plac_pkg.sv
// shared types, constants and helpers of the piecewise linear activation unit
`default_nettype none
package plac_pkg;

   localparam int DATA_W    = 16;
   localparam int ACCUM_W   = 32;
   localparam int NEURON_W  = 8;
   localparam int HINGE_W   = 3;
   localparam int HCOUNT_W  = 4;
   localparam int ADDR_W    = NEURON_W + HINGE_W;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int FRAC_W    = 8;
   localparam int PQ_W      = PROD_W - FRAC_W;
   localparam int SUM_W     = 28;
   localparam int OP_W      = 2;
   localparam int SEL_W     = 2;

   localparam logic [HCOUNT_W-1:0] HINGES = HCOUNT_W'(8);
   localparam logic [HCOUNT_W-1:0] HINGES_RESET = HCOUNT_W'(1);

   // request opcodes
   localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
   localparam logic [OP_W-1:0] OP_FORWARD  = 2'd1;
   localparam logic [OP_W-1:0] OP_BACKWARD = 2'd2;
   localparam logic [OP_W-1:0] OP_READ     = 2'd3;

   // multiplier operand selection
   localparam logic [SEL_W-1:0] MUL_SLOPE_DIST = 2'd0;
   localparam logic [SEL_W-1:0] MUL_GRAD_DIST  = 2'd1;
   localparam logic [SEL_W-1:0] MUL_GRAD_SLOPE = 2'd2;

   typedef struct packed {
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
      logic                     param_we;
      logic [ADDR_W-1:0]        param_addr;
      logic signed [DATA_W-1:0] slope_wr;
      logic signed [DATA_W-1:0] offset_wr;
      logic                     grad_we;
      logic [ADDR_W-1:0]        grad_addr;
      logic signed [ACCUM_W-1:0] sg_wr;
      logic signed [ACCUM_W-1:0] og_wr;
   } plac_mem_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  slope_rd;
      logic signed [DATA_W-1:0]  offset_rd;
      logic signed [ACCUM_W-1:0] sg_rd;
      logic signed [ACCUM_W-1:0] og_rd;
   } plac_mem_rsp_type;

   // clamp the running sum to the data range
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return DATA_W'(hi);
      end else if (v < lo) begin
         return DATA_W'(lo);
      end
      return v[DATA_W-1:0];
   endfunction

   // add a product to an accumulator with saturation
   function automatic logic signed [ACCUM_W-1:0] sat_acc_add(
      input logic signed [ACCUM_W-1:0] a,
      input logic signed [PQ_W-1:0]    d
   );
      logic signed [ACCUM_W:0] s;
      s = {a[ACCUM_W-1], a} + (ACCUM_W+1)'(d);
      if (s[ACCUM_W] != s[ACCUM_W-1]) begin
         return s[ACCUM_W] ? {1'b1, {(ACCUM_W-1){1'b0}}} : {1'b0, {(ACCUM_W-1){1'b1}}};
      end
      return s[ACCUM_W-1:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/plac_mac.sv
// shared signed multiplier with operand select and registered product
`default_nettype none
module plac_mac (
   input  wire logic                              clock,
   input  wire logic [plac_pkg::SEL_W-1:0]        sel,
   input  wire logic signed [plac_pkg::DATA_W-1:0] slope,
   input  wire logic signed [plac_pkg::DATA_W-1:0] gap,
   input  wire logic signed [plac_pkg::DATA_W-1:0] grad,
   output logic signed [plac_pkg::PQ_W-1:0]        prod_q8
);
   import plac_pkg::*;

   logic signed [DATA_W-1:0] opa;
   logic signed [DATA_W-1:0] opb;
   logic signed [PROD_W-1:0] prod_ff;

   always_comb begin
      case (sel)
         MUL_SLOPE_DIST: begin
            opa = slope;
            opb = gap;
         end
         MUL_GRAD_DIST: begin
            opa = grad;
            opb = gap;
         end
         MUL_GRAD_SLOPE: begin
            opa = grad;
            opb = slope;
         end
         default: begin
            opa = grad;
            opb = gap;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(opa) * PROD_W'(opb);
   end

   // arithmetic shift right is a floor to q16.8
   assign prod_q8 = prod_ff[PROD_W-1:FRAC_W];

endmodule
`default_nettype wire

### hw/rtl/plac_store.sv
// parameter tables and gradient accumulators, registered reads
`default_nettype none
module plac_store (
   input  wire logic                       clock,
   input  wire plac_pkg::plac_mem_cmd_type cmd,
   output plac_pkg::plac_mem_rsp_type      rsp
);
   import plac_pkg::*;

   localparam int ENTRIES = 1 << ADDR_W;

   logic [2*DATA_W-1:0]  param_mem [ENTRIES];
   logic [2*ACCUM_W-1:0] grad_mem  [ENTRIES];
   logic [2*DATA_W-1:0]  param_rd_ff;
   logic [2*ACCUM_W-1:0] grad_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.param_we) begin
         param_mem[cmd.param_addr] <= {cmd.slope_wr, cmd.offset_wr};
      end
      if (cmd.rd_en) begin
         param_rd_ff <= param_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grad_we) begin
         grad_mem[cmd.grad_addr] <= {cmd.sg_wr, cmd.og_wr};
      end
      if (cmd.rd_en) begin
         grad_rd_ff <= grad_mem[cmd.rd_addr];
      end
   end

   assign rsp.slope_rd  = param_rd_ff[2*DATA_W-1:DATA_W];
   assign rsp.offset_rd = param_rd_ff[DATA_W-1:0];
   assign rsp.sg_rd     = grad_rd_ff[2*ACCUM_W-1:ACCUM_W];
   assign rsp.og_rd     = grad_rd_ff[ACCUM_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/piecewise_linear_activation_unit_top.sv
// top level of the piecewise linear activation unit: sequencer and result register
`default_nettype none
// Adaptive piecewise linear activation, Q8.8. A request is taken when start is
// high and busy is low; its single result shows on the rsp_ ports for exactly
// one cycle with rsp_valid high, and the receiver cannot stall it. One shared
// 16x16 multiplier and one read port per table are walked over the hinges of
// the addressed neuron, so the request length follows the hinge count n
// (csr_hinges_in_use, clamped to 8): load completes in IDLE, read-and-clear
// walks READ and DIST, forward walks READ, DIST, MUL1 and ACC per hinge and
// backward adds MUL2 (two products per hinge). The result appears the cycle
// after the request ends and a new request may be taken in that same cycle.
// After reset, busy stays high while all 2048 gradient accumulator entries are
// swept to zero one entry a cycle. The hinge count register is always ready and
// may be written only while no request is in flight. Slope and offset entries
// read before being loaded give undefined results.
module piecewise_linear_activation_unit_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [plac_pkg::OP_W-1:0]           req_op,
   input  wire logic [plac_pkg::NEURON_W-1:0]       req_neuron,
   input  wire logic [plac_pkg::HINGE_W-1:0]        req_hinge,
   input  wire logic signed [plac_pkg::DATA_W-1:0]  req_activation_in,
   input  wire logic signed [plac_pkg::DATA_W-1:0]  req_grad_in,
   input  wire logic signed [plac_pkg::DATA_W-1:0]  req_slope_in,
   input  wire logic signed [plac_pkg::DATA_W-1:0]  req_offset_in,
   // result channel
   output logic                                     rsp_valid,
   output logic signed [plac_pkg::DATA_W-1:0]       rsp_value_out,
   output logic signed [plac_pkg::ACCUM_W-1:0]      rsp_slope_grad_out,
   output logic signed [plac_pkg::ACCUM_W-1:0]      rsp_offset_grad_out,
   // hinge count register
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [plac_pkg::HCOUNT_W-1:0]       csr_hinges_in_use
);
   import plac_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;  // zeroing sweep after reset
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [ST_W-1:0] ST_READ  = 3'd2;  // issue table read for one hinge
   localparam logic [ST_W-1:0] ST_DIST  = 3'd3;  // hinge distance, or read-and-clear result
   localparam logic [ST_W-1:0] ST_MUL1  = 3'd4;  // first product
   localparam logic [ST_W-1:0] ST_MUL2  = 3'd5;  // second product, backward only
   localparam logic [ST_W-1:0] ST_ACC   = 3'd6;  // sum and accumulator write back

   localparam logic signed [DATA_W:0] DIST_MAX = (DATA_W+1)'((1 << (DATA_W - 1)) - 1);

   // sequencer state
   logic [ST_W-1:0]          state_ff, state_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic [HINGE_W-1:0]       s_ff, s_in;
   logic [HCOUNT_W-1:0]      hcfg_ff, hcfg_in;

   // latched request
   logic [OP_W-1:0]          op_ff, op_in;
   logic [NEURON_W-1:0]      nrn_ff, nrn_in;
   logic [HINGE_W-1:0]       hg_ff, hg_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] g_ff, g_in;

   // datapath registers
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] dist_ff, dist_in;
   logic signed [PQ_W-1:0]   wd_ff, wd_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  value_ff, value_in;
   logic signed [ACCUM_W-1:0] sg_ff, sg_in;
   logic signed [ACCUM_W-1:0] og_ff, og_in;

   logic [HCOUNT_W-1:0]       n_cnt;
   logic                      last_hinge;
   logic                      x_pos;
   logic [ADDR_W-1:0]         cur_addr;
   logic signed [DATA_W:0]    diff;
   logic signed [PQ_W-1:0]    prod_q8;
   logic signed [PQ_W-1:0]    od;
   logic signed [SUM_W-1:0]   acc_next;
   logic [SEL_W-1:0]          mul_sel;
   plac_mem_cmd_type          mem_cmd;
   plac_mem_rsp_type          mem_rsp;

   plac_mac u_mac (
      .clock   (clock),
      .sel     (mul_sel),
      .slope   (mem_rsp.slope_rd),
      .gap     (dist_ff),
      .grad    (g_ff),
      .prod_q8 (prod_q8)
   );

   plac_store u_store (
      .clock (clock),
      .cmd   (mem_cmd),
      .rsp   (mem_rsp)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_value_out       = value_ff;
   assign rsp_slope_grad_out  = sg_ff;
   assign rsp_offset_grad_out = og_ff;

   // hinge count clamped to the table depth, zero means no hinge terms
   assign n_cnt      = (hcfg_ff > HINGES) ? HINGES : hcfg_ff;
   assign last_hinge = (({1'b0, s_ff} + HCOUNT_W'(1)) == n_cnt);
   assign x_pos      = !req_activation_in[DATA_W-1] && (req_activation_in != '0);

   // read and clear uses the request hinge, forward and backward walk the hinges
   assign cur_addr = {nrn_ff, (op_ff == OP_READ) ? hg_ff : s_ff};

   // offset minus x, clamped to [0, max data] in ST_DIST
   assign diff = {mem_rsp.offset_rd[DATA_W-1], mem_rsp.offset_rd}
               - {x_ff[DATA_W-1], x_ff};

   // offset gradient only counts on an active hinge
   assign od = (dist_ff != '0) ? prod_q8 : '0;

   assign acc_next = (op_ff == OP_FORWARD) ? acc_ff + SUM_W'(prod_q8)
                                           : acc_ff - SUM_W'(od);

   always_comb begin
      if (state_ff == ST_MUL2) begin
         mul_sel = MUL_GRAD_SLOPE;
      end else if (op_ff == OP_FORWARD) begin
         mul_sel = MUL_SLOPE_DIST;
      end else begin
         mul_sel = MUL_GRAD_DIST;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      s_in         = s_ff;
      hcfg_in      = hcfg_ff;
      op_in        = op_ff;
      nrn_in       = nrn_ff;
      hg_in        = hg_ff;
      x_in         = x_ff;
      g_in         = g_ff;
      acc_in       = acc_ff;
      dist_in      = dist_ff;
      wd_in        = wd_ff;
      rsp_valid_in = 1'b0;
      value_in     = value_ff;
      sg_in        = sg_ff;
      og_in        = og_ff;

      mem_cmd            = '0;
      mem_cmd.rd_addr    = cur_addr;
      mem_cmd.param_addr = {req_neuron, req_hinge};
      mem_cmd.slope_wr   = req_slope_in;
      mem_cmd.offset_wr  = req_offset_in;
      mem_cmd.grad_addr  = cur_addr;

      if (csr_valid && csr_ready) begin
         hcfg_in = csr_hinges_in_use;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_cmd.grad_we   = 1'b1;
            mem_cmd.grad_addr = clr_ff;
            clr_in            = clr_ff + ADDR_W'(1);
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in  = req_op;
               nrn_in = req_neuron;
               hg_in  = req_hinge;
               x_in   = req_activation_in;
               g_in   = req_grad_in;
               s_in   = '0;
               value_in = '0;
               sg_in    = '0;
               og_in    = '0;
               if (req_op == OP_FORWARD) begin
                  acc_in = x_pos ? SUM_W'(req_activation_in) : '0;
               end else begin
                  acc_in = x_pos ? SUM_W'(req_grad_in) : '0;
               end
               case (req_op)
                  OP_LOAD: begin
                     mem_cmd.param_we = 1'b1;
                     rsp_valid_in     = 1'b1;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     // no hinge terms: result is the linear part alone
                     if (n_cnt == '0) begin
                        rsp_valid_in = 1'b1;
                        if (req_op == OP_FORWARD) begin
                           value_in = x_pos ? req_activation_in : '0;
                        end else begin
                           value_in = x_pos ? req_grad_in : '0;
                        end
                     end else begin
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_cmd.rd_en = 1'b1;
            state_in      = ST_DIST;
         end
         ST_DIST: begin
            if (op_ff == OP_READ) begin
               // hand out the accumulated pair and clear the entry
               sg_in           = mem_rsp.sg_rd;
               og_in           = mem_rsp.og_rd;
               value_in        = '0;
               rsp_valid_in    = 1'b1;
               mem_cmd.grad_we = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               if (diff < 0) begin
                  dist_in = '0;
               end else if (diff > DIST_MAX) begin
                  dist_in = DIST_MAX[DATA_W-1:0];
               end else begin
                  dist_in = diff[DATA_W-1:0];
               end
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = (op_ff == OP_FORWARD) ? ST_ACC : ST_MUL2;
         end
         ST_MUL2: begin
            // keep g*dist while the multiplier forms g*slope
            wd_in    = prod_q8;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_next;
            if (op_ff == OP_BACKWARD) begin
               mem_cmd.grad_we = 1'b1;
               mem_cmd.sg_wr   = sat_acc_add(mem_rsp.sg_rd, wd_ff);
               mem_cmd.og_wr   = sat_acc_add(mem_rsp.og_rd, od);
            end
            if (last_hinge) begin
               value_in     = sat_data(acc_next);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               s_in     = s_ff + HINGE_W'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         s_ff         <= '0;
         hcfg_ff      <= HINGES_RESET;
         op_ff        <= OP_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s_ff         <= s_in;
         hcfg_ff      <= hcfg_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nrn_ff   <= nrn_in;
      hg_ff    <= hg_in;
      x_ff     <= x_in;
      g_ff     <= g_in;
      acc_ff   <= acc_in;
      dist_ff  <= dist_in;
      wd_ff    <= wd_in;
      value_ff <= value_in;
      sg_ff    <= sg_in;
      og_ff    <= og_in;
   end

endmodule
`default_nettype wire
